### sv/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared widths, opcodes, status codes and sequencer states of the deque.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned DepthDefault = 64;
  localparam int unsigned DataW        = 64;
  localparam int unsigned OpW          = 3;
  localparam int unsigned PosW         = 6;
  localparam int unsigned StatusW      = 3;
  localparam int unsigned CountOutW    = 7;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_POP_FRONT  = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4,
    OP_REPLACE    = 3'd5
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_RDWAIT = 5'b00100,
    S_SCAN   = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

endpackage

### sv/bounded_deque_with_search_replace_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search_replace_unit
// Bounded deque of signed 64-bit words in a ring buffer, with indexed read
// and search-and-replace from the front.
// ----------------------------------------------------------------------------
// One word is taken at a time; each returns one result word. Pushes, pops
// and no-op codes pass through the execute and done states to the output
// register, an indexed read adds a wait state for the registered memory
// read, and a replace adds a scan that reads one ring entry per cycle
// through the single read port, up to the element count. The next word
// is accepted in the cycle after the output register loads. A new word
// is accepted while a finished result still waits at the output.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_replace_unit #(
  parameter int unsigned DEPTH = dq_pkg::DepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [dq_pkg::OpW-1:0]              opcode_i,
  input  logic signed [dq_pkg::DataW-1:0]     value_i,
  input  logic signed [dq_pkg::DataW-1:0]     new_value_i,
  input  logic [dq_pkg::PosW-1:0]             position_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dq_pkg::StatusW-1:0]          status_o,
  output logic signed [dq_pkg::DataW-1:0]     read_value_o,
  output logic [dq_pkg::CountOutW-1:0]        element_count_o
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned PW    = (CW > dq_pkg::PosW) ? CW : dq_pkg::PosW;
  localparam int unsigned DW    = dq_pkg::DataW;
  localparam int unsigned OutCW = dq_pkg::CountOutW;

  dq_pkg::state_e              state_q, state_d;
  logic [dq_pkg::OpW-1:0]      op_q, op_d;
  logic [DW-1:0]               val_q, val_d;
  logic [DW-1:0]               nval_q, nval_d;
  logic [dq_pkg::PosW-1:0]     pos_q, pos_d;
  logic [AW-1:0]               front_q, front_d;
  logic [CW-1:0]               count_q, count_d;
  logic [CW-1:0]               idx_q, idx_d;
  logic [AW-1:0]               scan_slot_q, scan_slot_d;
  dq_pkg::status_e             res_status_q, res_status_d;
  logic [DW-1:0]               res_read_q, res_read_d;
  logic                        out_valid_q, out_valid_d;
  dq_pkg::status_e             out_status_q, out_status_d;
  logic [DW-1:0]               out_read_q, out_read_d;
  logic [OutCW-1:0]            out_count_q, out_count_d;

  logic [CW-1:0]               offset;
  logic [AW-1:0]               slot_sum;
  logic [AW-1:0]               front_dec;
  logic [CW-1:0]               idx_next;
  logic                        full;
  logic                        empty;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [DW-1:0]               mem_wdata;
  logic [DW-1:0]               mem_rdata;

  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign idx_next  = CW'(idx_q + CW'(1));

  always_comb begin
    offset = '0;
    if (state_q == dq_pkg::S_SCAN) begin
      offset = idx_next;
    end else begin
      case (dq_pkg::op_e'(op_q))
        dq_pkg::OP_POP_FRONT: offset = CW'(1);
        dq_pkg::OP_PUSH_BACK: offset = count_q;
        dq_pkg::OP_READ:      offset = CW'(pos_q);
        default:              offset = '0;
      endcase
    end
  end

  dq_slot #(
    .DEPTH(DEPTH)
  ) u_slot (
    .base_i  (front_q),
    .offset_i(offset),
    .slot_o  (slot_sum)
  );

  dq_ram #(
    .DEPTH(DEPTH),
    .WIDTH(DW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(slot_sum),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    val_d        = val_q;
    nval_d       = nval_q;
    pos_d        = pos_q;
    front_d      = front_q;
    count_d      = count_q;
    idx_d        = idx_q;
    scan_slot_d  = scan_slot_q;
    res_status_d = res_status_q;
    res_read_d   = res_read_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_read_d   = out_read_q;
    out_count_d  = out_count_q;
    mem_we       = 1'b0;
    mem_waddr    = scan_slot_q;
    mem_wdata    = val_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      dq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_d    = opcode_i;
          val_d   = value_i;
          nval_d  = new_value_i;
          pos_d   = position_i;
          state_d = dq_pkg::S_EXEC;
        end
      end
      dq_pkg::S_EXEC: begin
        res_read_d   = '0;
        res_status_d = dq_pkg::ST_OK;
        state_d      = dq_pkg::S_DONE;
        case (dq_pkg::op_e'(op_q))
          dq_pkg::OP_PUSH_FRONT: begin
            if (full) begin
              res_status_d = dq_pkg::ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = front_dec;
              front_d   = front_dec;
              count_d   = count_q + CW'(1);
            end
          end
          dq_pkg::OP_POP_FRONT: begin
            if (empty) begin
              res_status_d = dq_pkg::ST_EMPTY;
            end else begin
              front_d = slot_sum;
              count_d = count_q - CW'(1);
            end
          end
          dq_pkg::OP_PUSH_BACK: begin
            if (full) begin
              res_status_d = dq_pkg::ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = slot_sum;
              count_d   = count_q + CW'(1);
            end
          end
          dq_pkg::OP_POP_BACK: begin
            if (empty) begin
              res_status_d = dq_pkg::ST_EMPTY;
            end else begin
              count_d = count_q - CW'(1);
            end
          end
          dq_pkg::OP_READ: begin
            if (PW'(pos_q) >= PW'(count_q)) begin
              res_status_d = dq_pkg::ST_RANGE;
            end else begin
              state_d = dq_pkg::S_RDWAIT;
            end
          end
          dq_pkg::OP_REPLACE: begin
            if (empty) begin
              res_status_d = dq_pkg::ST_NOTFOUND;
            end else begin
              idx_d       = '0;
              scan_slot_d = slot_sum;
              state_d     = dq_pkg::S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      dq_pkg::S_RDWAIT: begin
        res_read_d = mem_rdata;
        state_d    = dq_pkg::S_DONE;
      end
      dq_pkg::S_SCAN: begin
        if (mem_rdata == val_q) begin
          mem_we       = 1'b1;
          mem_waddr    = scan_slot_q;
          mem_wdata    = nval_q;
          res_status_d = dq_pkg::ST_OK;
          state_d      = dq_pkg::S_DONE;
        end else if (idx_next == count_q) begin
          res_status_d = dq_pkg::ST_NOTFOUND;
          state_d      = dq_pkg::S_DONE;
        end else begin
          idx_d       = idx_next;
          scan_slot_d = slot_sum;
        end
      end
      dq_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_read_d   = res_read_q;
          out_count_d  = OutCW'(count_q);
          state_d      = dq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dq_pkg::S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    val_q        <= val_d;
    nval_q       <= nval_d;
    pos_q        <= pos_d;
    idx_q        <= idx_d;
    scan_slot_q  <= scan_slot_d;
    res_status_q <= res_status_d;
    res_read_q   <= res_read_d;
    out_status_q <= out_status_d;
    out_read_q   <= out_read_d;
    out_count_q  <= out_count_d;
  end

  assign in_ready_o      = (state_q == dq_pkg::S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign read_value_o    = out_read_q;
  assign element_count_o = out_count_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("element count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q < AW'(DEPTH) || DEPTH == (1 << AW))
    else $error("front slot outside ring");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == dq_pkg::S_EXEC)
    else $error("accepted word not executed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != dq_pkg::ST_OK |-> read_value_o == '0)
    else $error("read value set on failed operation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dq_pkg::S_SCAN |-> idx_q < count_q)
    else $error("scan index past element count");

endmodule

### sv/dq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ram
// Ring storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int unsigned DEPTH = dq_pkg::DepthDefault,
  parameter int unsigned WIDTH = dq_pkg::DataW,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/dq_slot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_slot
// Shared slot adder: base slot plus offset, wrapped modulo the ring depth.
// ----------------------------------------------------------------------------
module dq_slot #(
  parameter int unsigned DEPTH = dq_pkg::DepthDefault,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic [AW-1:0] base_i,
  input  logic [CW-1:0] offset_i,
  output logic [AW-1:0] slot_o
);

  logic [AW:0] sum;

  always_comb begin
    sum = (AW + 1)'(base_i) + (AW + 1)'(offset_i);
    if (sum >= (AW + 1)'(DEPTH)) begin
      slot_o = AW'(sum - (AW + 1)'(DEPTH));
    end else begin
      slot_o = AW'(sum);
    end
  end

endmodule

### test/bounded_deque_with_search_replace_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search_replace_unit_test
// Drives opcode words into the deque and checks every result word, in order,
// against table results or a shadow deque kept in the bench. A short table
// covers empty removes, out-of-range reads, misses, unused opcodes and extreme
// values; random phases then fill the list to full, drain it to empty, mix
// reads and replaces and send random opcodes, idling both channels at random.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_replace_unit_test;

  localparam int          DEPTH       = dq_pkg::DepthDefault;
  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int          DRAIN_WAIT  = 80;
  localparam int          NUM_ROWS    = 22;
  localparam int          NUM_SEGS    = 16;
  localparam int          SEG_WORDS   = 100;

  localparam logic [dq_pkg::OpW-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [dq_pkg::OpW-1:0] OP_SPARE_7 = 3'd7;

  localparam logic signed [dq_pkg::DataW-1:0] MAX_VAL =
    {1'b0, {(dq_pkg::DataW-1){1'b1}}};
  localparam logic signed [dq_pkg::DataW-1:0] MIN_VAL =
    {1'b1, {(dq_pkg::DataW-1){1'b0}}};
  localparam logic signed [dq_pkg::DataW-1:0] ALL_ONES = '1;
  localparam logic signed [dq_pkg::DataW-1:0] ALT_55 = {(dq_pkg::DataW/2){2'b01}};
  localparam logic signed [dq_pkg::DataW-1:0] ALT_AA = {(dq_pkg::DataW/2){2'b10}};

  typedef enum int {
    PH_FILL,
    PH_MIXED,
    PH_DRAIN,
    PH_NOISE
  } phase_e;

  typedef struct packed {
    logic [dq_pkg::StatusW-1:0]      status;
    logic signed [dq_pkg::DataW-1:0] read_value;
    logic [dq_pkg::CountOutW-1:0]    element_count;
  } deque_result_t;

  typedef struct {
    logic [dq_pkg::OpW-1:0]          op;
    logic signed [dq_pkg::DataW-1:0] value;
    logic signed [dq_pkg::DataW-1:0] new_value;
    logic [dq_pkg::PosW-1:0]         position;
    bit                              typed;
    deque_result_t                   result;
  } stim_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic [dq_pkg::OpW-1:0]          opcode_i;
  logic signed [dq_pkg::DataW-1:0] value_i;
  logic signed [dq_pkg::DataW-1:0] new_value_i;
  logic [dq_pkg::PosW-1:0]         position_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic [dq_pkg::StatusW-1:0]      status_o;
  logic signed [dq_pkg::DataW-1:0] read_value_o;
  logic [dq_pkg::CountOutW-1:0]    element_count_o;

  logic signed [dq_pkg::DataW-1:0] shadow_ring [DEPTH];
  int                              shadow_front;
  int                              shadow_count;
  deque_result_t                   awaited_results [$];
  stim_row_t                       stim_rows [NUM_ROWS];
  int unsigned                     error_count;
  int unsigned                     cycle_count;
  bit                              calm;

  bounded_deque_with_search_replace_unit #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .value_i        (value_i),
    .new_value_i    (new_value_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .read_value_o   (read_value_o),
    .element_count_o(element_count_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int ring_slot(input int offset);
    return (shadow_front + offset) % DEPTH;
  endfunction

  function automatic deque_result_t apply_deque_op(
    input logic [dq_pkg::OpW-1:0]          op,
    input logic signed [dq_pkg::DataW-1:0] value,
    input logic signed [dq_pkg::DataW-1:0] new_value,
    input logic [dq_pkg::PosW-1:0]         position
  );
    deque_result_t res;
    bit            hit;
    res.status     = dq_pkg::ST_OK;
    res.read_value = '0;
    hit            = 1'b0;
    case (op)
      dq_pkg::OP_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          res.status = dq_pkg::ST_FULL;
        end else begin
          shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
          shadow_ring[shadow_front] = value;
          shadow_count++;
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          res.status = dq_pkg::ST_EMPTY;
        end else begin
          shadow_front = ring_slot(1);
          shadow_count--;
        end
      end
      dq_pkg::OP_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          res.status = dq_pkg::ST_FULL;
        end else begin
          shadow_ring[ring_slot(shadow_count)] = value;
          shadow_count++;
        end
      end
      dq_pkg::OP_POP_BACK: begin
        if (shadow_count == 0) res.status = dq_pkg::ST_EMPTY;
        else shadow_count--;
      end
      dq_pkg::OP_READ: begin
        if (int'(position) >= shadow_count) res.status = dq_pkg::ST_RANGE;
        else res.read_value = shadow_ring[ring_slot(int'(position))];
      end
      dq_pkg::OP_REPLACE: begin
        res.status = dq_pkg::ST_NOTFOUND;
        for (int i = 0; i < shadow_count; i++) begin
          if (!hit && shadow_ring[ring_slot(i)] == value) begin
            shadow_ring[ring_slot(i)] = new_value;
            res.status = dq_pkg::ST_OK;
            hit = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.element_count = shadow_count[dq_pkg::CountOutW-1:0];
    return res;
  endfunction

  function automatic logic signed [dq_pkg::DataW-1:0] pick_value();
    int r;
    r = $urandom_range(9);
    if (r < 4) return dq_pkg::DataW'($signed($urandom_range(7)) - 3);
    if (r == 4) begin
      case ($urandom_range(3))
        0: return MAX_VAL;
        1: return MIN_VAL;
        2: return ALL_ONES;
        default: return '0;
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  function automatic logic [dq_pkg::OpW-1:0] pick_op(input phase_e phase);
    int r;
    r = $urandom_range(99);
    case (phase)
      PH_FILL: begin
        if (r < 35) return dq_pkg::OP_PUSH_FRONT;
        if (r < 70) return dq_pkg::OP_PUSH_BACK;
        if (r < 78) return dq_pkg::OP_POP_FRONT;
        if (r < 85) return dq_pkg::OP_POP_BACK;
        if (r < 93) return dq_pkg::OP_READ;
        return dq_pkg::OP_REPLACE;
      end
      PH_DRAIN: begin
        if (r < 10) return dq_pkg::OP_PUSH_FRONT;
        if (r < 20) return dq_pkg::OP_PUSH_BACK;
        if (r < 45) return dq_pkg::OP_POP_FRONT;
        if (r < 70) return dq_pkg::OP_POP_BACK;
        if (r < 85) return dq_pkg::OP_READ;
        return dq_pkg::OP_REPLACE;
      end
      PH_MIXED: begin
        if (r < 15) return dq_pkg::OP_PUSH_FRONT;
        if (r < 30) return dq_pkg::OP_PUSH_BACK;
        if (r < 38) return dq_pkg::OP_POP_FRONT;
        if (r < 46) return dq_pkg::OP_POP_BACK;
        if (r < 73) return dq_pkg::OP_READ;
        return dq_pkg::OP_REPLACE;
      end
      default: return dq_pkg::OpW'($urandom_range(7));
    endcase
  endfunction

  // Present one word at a falling edge and hold it until accepted.
  task automatic send_word(
    input logic [dq_pkg::OpW-1:0]          op,
    input logic signed [dq_pkg::DataW-1:0] value,
    input logic signed [dq_pkg::DataW-1:0] new_value,
    input logic [dq_pkg::PosW-1:0]         position
  );
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    value_i     <= value;
    new_value_i <= new_value;
    position_i  <= position;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic set_row(
    input int                              idx,
    input logic [dq_pkg::OpW-1:0]          op,
    input logic signed [dq_pkg::DataW-1:0] value,
    input logic signed [dq_pkg::DataW-1:0] new_value,
    input logic [dq_pkg::PosW-1:0]         position,
    input bit                              typed,
    input logic [dq_pkg::StatusW-1:0]      status,
    input logic signed [dq_pkg::DataW-1:0] read_value,
    input logic [dq_pkg::CountOutW-1:0]    count
  );
    stim_rows[idx] = '{op, value, new_value, position, typed,
                       '{status, read_value, count}};
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 22);
  end

  always @(posedge clk_i) begin
    deque_result_t got;
    deque_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{status_o, read_value_o, element_count_o};
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d read=%h count=%0d", $time,
                 got.status, got.read_value, got.element_count);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch exp status=%0d read=%h count=%0d", $time,
                   want.status, want.read_value, want.element_count);
          $display("%0t:          got status=%0d read=%h count=%0d", $time,
                   got.status, got.read_value, got.element_count);
          error_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    deque_result_t                   res;
    logic [dq_pkg::OpW-1:0]          op;
    logic signed [dq_pkg::DataW-1:0] val;
    logic [dq_pkg::PosW-1:0]         pos;
    phase_e                          phase;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    opcode_i     = '0;
    value_i      = '0;
    new_value_i  = '0;
    position_i   = '0;
    error_count  = 0;
    shadow_front = 0;
    shadow_count = 0;
    calm         = 1'b0;

    set_row(0,  dq_pkg::OP_READ,       '0,       '0,       6'd0,  1,
            dq_pkg::ST_RANGE,    '0,       7'd0);
    set_row(1,  dq_pkg::OP_POP_FRONT,  '0,       '0,       6'd0,  1,
            dq_pkg::ST_EMPTY,    '0,       7'd0);
    set_row(2,  dq_pkg::OP_POP_BACK,   ALL_ONES, '0,       6'd63, 1,
            dq_pkg::ST_EMPTY,    '0,       7'd0);
    set_row(3,  dq_pkg::OP_REPLACE,    '0,       ALL_ONES, 6'd0,  1,
            dq_pkg::ST_NOTFOUND, '0,       7'd0);
    set_row(4,  OP_SPARE_6,            MAX_VAL,  MIN_VAL,  6'd63, 1,
            dq_pkg::ST_OK,       '0,       7'd0);
    set_row(5,  OP_SPARE_7,            MIN_VAL,  MAX_VAL,  6'd0,  1,
            dq_pkg::ST_OK,       '0,       7'd0);
    set_row(6,  dq_pkg::OP_PUSH_FRONT, MAX_VAL,  '0,       6'd0,  1,
            dq_pkg::ST_OK,       '0,       7'd1);
    set_row(7,  dq_pkg::OP_PUSH_BACK,  MIN_VAL,  '0,       6'd0,  1,
            dq_pkg::ST_OK,       '0,       7'd2);
    set_row(8,  dq_pkg::OP_PUSH_FRONT, '0,       '0,       6'd0,  1,
            dq_pkg::ST_OK,       '0,       7'd3);
    set_row(9,  dq_pkg::OP_PUSH_BACK,  ALL_ONES, '0,       6'd0,  1,
            dq_pkg::ST_OK,       '0,       7'd4);
    set_row(10, dq_pkg::OP_READ,       '0,       '0,       6'd0,  1,
            dq_pkg::ST_OK,       '0,       7'd4);
    set_row(11, dq_pkg::OP_READ,       '0,       '0,       6'd1,  1,
            dq_pkg::ST_OK,       MAX_VAL,  7'd4);
    set_row(12, dq_pkg::OP_READ,       '0,       '0,       6'd3,  1,
            dq_pkg::ST_OK,       ALL_ONES, 7'd4);
    set_row(13, dq_pkg::OP_READ,       '0,       '0,       6'd4,  1,
            dq_pkg::ST_RANGE,    '0,       7'd4);
    set_row(14, dq_pkg::OP_READ,       ALL_ONES, ALL_ONES, 6'd63, 1,
            dq_pkg::ST_RANGE,    '0,       7'd4);
    set_row(15, dq_pkg::OP_REPLACE,    MIN_VAL,  ALT_55,   6'd0,  1,
            dq_pkg::ST_OK,       '0,       7'd4);
    set_row(16, dq_pkg::OP_REPLACE,    64'sd12345, ALT_AA, 6'd0,  1,
            dq_pkg::ST_NOTFOUND, '0,       7'd4);
    set_row(17, dq_pkg::OP_REPLACE,    '0,       ALT_AA,   6'd0,  0,
            dq_pkg::ST_OK,       '0,       7'd0);
    set_row(18, dq_pkg::OP_READ,       '0,       '0,       6'd2,  0,
            dq_pkg::ST_OK,       '0,       7'd0);
    set_row(19, dq_pkg::OP_POP_FRONT,  '0,       '0,       6'd0,  0,
            dq_pkg::ST_OK,       '0,       7'd0);
    set_row(20, dq_pkg::OP_POP_BACK,   '0,       '0,       6'd0,  0,
            dq_pkg::ST_OK,       '0,       7'd0);
    set_row(21, dq_pkg::OP_READ,       '0,       '0,       6'd0,  0,
            dq_pkg::ST_OK,       '0,       7'd0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i]) begin
      send_word(stim_rows[i].op, stim_rows[i].value, stim_rows[i].new_value,
                stim_rows[i].position);
      res = apply_deque_op(stim_rows[i].op, stim_rows[i].value,
                           stim_rows[i].new_value, stim_rows[i].position);
      awaited_results.push_back(stim_rows[i].typed ? stim_rows[i].result : res);
    end

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      phase = phase_e'(seg % 4);
      calm  = (seg == 6) || (seg == 7);
      for (int k = 0; k < SEG_WORDS; k++) begin
        op  = pick_op(phase);
        val = pick_value();
        // aim replaces at live elements half the time
        if (op == dq_pkg::OP_REPLACE && shadow_count > 0 && $urandom_range(1))
          val = shadow_ring[ring_slot($urandom_range(shadow_count - 1))];
        if (op == dq_pkg::OP_READ && shadow_count > 0 && $urandom_range(99) < 70)
          pos = dq_pkg::PosW'($urandom_range(shadow_count < 63 ? shadow_count : 63));
        else
          pos = dq_pkg::PosW'($urandom_range(63));
        send_word(op, val, pick_value(), pos);
        awaited_results.push_back(apply_deque_op(op, val, new_value_i, pos));
      end
    end
    calm = 1'b0;

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/dq_pkg.sv
sv/dq_ram.sv
sv/dq_slot.sv
sv/bounded_deque_with_search_replace_unit.sv
test/bounded_deque_with_search_replace_unit_test.sv
